/* hdl/lfrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lfrs_pkg;

   // Frame store geometry: 32 columns of 32 rows, one byte per entry.
   localparam int STORE_DEPTH = 1024;
   localparam int STORE_AW    = 10;

   // Scan phases after the 32 data phases.
   localparam logic [5:0] PH_PAGE = 6'd32;
   localparam logic [5:0] PH_ADDR = 6'd33;
   localparam logic [5:0] PH_READ = 6'd34;

   localparam logic [7:0] CMD_GFX  = 8'h80;
   localparam logic [7:0] BUS_PULL = 8'hFF;

   typedef enum logic [1:0] {
      OP_DRAW  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TICK  = 2'd2
   } lfrs_op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIXEL,
      ST_TICK
   } lfrs_state_type;

endpackage

`default_nettype wire

/* hdl/lfrs_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lfrs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] x;
   logic [7:0] y;
   logic       color;
   logic [7:0] pins_in;

   modport source (output valid, op, x, y, color, pins_in, input ready);
   modport sink   (input valid, op, x, y, color, pins_in, output ready);
endinterface

interface lfrs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       data_drive;
   logic       reg_select;
   logic       strobe_res;
   logic       backlight;
   logic       adc_start;
   logic [7:0] keys;

   modport source (output valid, data_out, data_drive, reg_select, strobe_res, backlight,
                   adc_start, keys, input ready);
   modport sink   (input valid, data_out, data_drive, reg_select, strobe_res, backlight,
                   adc_start, keys, output ready);
endinterface

interface lfrs_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] brightness;

   modport source (output valid, brightness, input ready);
   modport sink   (input valid, brightness, output ready);
endinterface

`default_nettype wire

/* hdl/lcd_framebuffer_refresh_scanner_top.sv */
// Graphic LCD frame store and refresh scanner. Request transactions carry
// one of three operations: draw a pixel, clear the frame store, or advance
// the refresh scan by one tick; only a tick produces a response transaction.
// The 1024-byte frame store sits in one synchronous RAM with a registered
// read. A pixel draw reads the byte, then modifies and writes it back; a
// tick reads the scanned byte, then updates the scan state; and a clear
// zeroes the RAM one byte per cycle. After reset the same sweep runs before
// the first request is taken; brightness writes are accepted at any time. The
// response register holds a tick result until it is taken, and draws and
// clears keep flowing behind it; only a following tick waits for the
// response slot.
`timescale 1ns / 1ps
`default_nettype none

module lcd_framebuffer_refresh_scanner_top
   import lfrs_pkg::*;
#(
   parameter int WIDTH      = 128,
   parameter int HEIGHT     = 64,
   parameter int BRIGHT_MAX = 32,
   parameter int BRIGHT_MIN = 0
) (
   input  wire         clock,
   input  wire         reset,
   lfrs_req_if.sink    req_port,
   lfrs_rsp_if.source  rsp_port,
   lfrs_csr_if.sink    csr_port
);

   // Frame store RAM and its registered read data.
   logic [7:0]          frame_mem [STORE_DEPTH];
   logic [7:0]          rd_data_ff;
   logic                mem_re;
   logic [STORE_AW-1:0] mem_raddr;
   logic                mem_we;
   logic [STORE_AW-1:0] mem_waddr;
   logic [7:0]          mem_wdata;

   lfrs_state_type state_ff, state_in;

   logic                req_accept;
   logic                tick_go;
   logic                out_free;

   // Sweep counter used by both the reset clear and the clear operation.
   logic [STORE_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // Pending pixel write, captured on acceptance.
   logic [STORE_AW-1:0] pix_idx_ff, pix_idx_in;
   logic [7:0]          pix_mask_ff, pix_mask_in;
   logic                pix_color_ff, pix_color_in;
   logic [7:0]          pins_ff;

   // Pixel addressing for the incoming request.
   logic                pix_on_screen;
   logic [4:0]          pix_col;
   logic [STORE_AW-1:0] tick_addr;

   logic [5:0]          brightness_ff;

   // Scan state. The response payload is driven straight from these
   // registers; they change only when a tick is issued into a free slot.
   logic [4:0] page_row_ff, page_row_in;
   logic [5:0] scan_phase_ff, scan_phase_in;
   logic [5:0] pwm_count_ff, pwm_count_in;
   logic [7:0] pins_latch_ff, pins_latch_in;
   logic       rs_level_ff, rs_level_in;
   logic       light_level_ff, light_level_in;
   logic       adc_toggle_ff, adc_toggle_in;
   logic [7:0] bus_level_ff, bus_level_in;
   logic       drive_level_ff, drive_level_in;
   logic       strobe_ff, strobe_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic [5:0] phase_step;
   logic [5:0] pwm_step;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   assign req_accept = req_port.valid && req_port.ready;
   assign out_free   = !rsp_valid_ff || rsp_port.ready;

   // The brightness register takes a write in any cycle.
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= 6'd0;
      end else if (csr_port.valid && csr_port.ready) begin
         brightness_ff <= csr_port.brightness;
      end
   end

   // ---------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------
   // Rows in the lower half of the screen fold into columns 16 to 31.
   always_comb begin
      pix_on_screen = ({1'b0, req_port.x} < 9'(WIDTH)) && ({1'b0, req_port.y} < 9'(HEIGHT));
      pix_col       = req_port.x[7:3] + ((req_port.y >= 8'd32) ? 5'd16 : 5'd0);
      pix_idx_in    = {pix_col, req_port.y[4:0]};
      pix_mask_in   = 8'h80 >> req_port.x[2:0];
      pix_color_in  = req_port.color;
      tick_addr     = {scan_phase_ff[4:0], page_row_ff};
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_idx_ff   <= pix_idx_in;
         pix_mask_ff  <= pix_mask_in;
         pix_color_ff <= pix_color_in;
         pins_ff      <= req_port.pins_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_port.op)
                  OP_DRAW: begin
                     if (pix_on_screen) begin
                        state_in = ST_PIXEL;
                     end
                  end
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_TICK:  state_in = ST_TICK;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_PIXEL: state_in = ST_IDLE;
         ST_TICK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_port.ready = 1'b0;
      mem_re         = 1'b0;
      mem_raddr      = tick_addr;
      mem_we         = 1'b0;
      mem_waddr      = pix_idx_ff;
      mem_wdata      = rd_data_ff;
      tick_go        = 1'b0;
      clr_cnt_in     = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = 8'h00;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            req_port.ready = 1'b1;
            clr_cnt_in     = '0;
            // A read is issued for every accepted draw or tick; the data is
            // held in the read register until the next read.
            if (req_accept && (req_port.op == OP_DRAW || req_port.op == OP_TICK)) begin
               mem_re = 1'b1;
            end
            if (req_port.op == OP_DRAW) begin
               mem_raddr = pix_idx_in;
            end
         end
         ST_PIXEL: begin
            mem_we    = 1'b1;
            mem_waddr = pix_idx_ff;
            mem_wdata = pix_color_ff ? (rd_data_ff | pix_mask_ff)
                                     : (rd_data_ff & ~pix_mask_ff);
         end
         ST_TICK: begin
            tick_go = out_free;
         end
         default: begin
            req_port.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Frame store RAM
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------------
   // Refresh scan update, applied once per tick
   // ---------------------------------------------------------------------
   always_comb begin
      page_row_in    = page_row_ff;
      pins_latch_in  = pins_latch_ff;
      rs_level_in    = rs_level_ff;
      bus_level_in   = bus_level_ff;
      drive_level_in = drive_level_ff;
      strobe_in      = 1'b1;
      adc_toggle_in  = ~adc_toggle_ff;

      case (scan_phase_ff)
         PH_PAGE: begin
            rs_level_in  = 1'b0;
            page_row_in  = page_row_ff + 1'b1;
            bus_level_in = CMD_GFX | {3'b000, page_row_in};
         end
         PH_ADDR: begin
            // The set-column command is strobed, then the bus is released
            // to its pull-ups for the key sample that follows.
            bus_level_in   = BUS_PULL;
            drive_level_in = 1'b0;
         end
         PH_READ: begin
            pins_latch_in  = pins_ff;
            drive_level_in = 1'b1;
            strobe_in      = 1'b0;
         end
         default: begin
            bus_level_in = rd_data_ff;
         end
      endcase

      phase_step = scan_phase_ff + 1'b1;
      if (phase_step > PH_READ) begin
         scan_phase_in = 6'd0;
         rs_level_in   = 1'b1;
      end else begin
         scan_phase_in = phase_step;
      end

      pwm_step = pwm_count_ff + 1'b1;
      if (pwm_step >= 6'(BRIGHT_MAX)) begin
         pwm_count_in = 6'(BRIGHT_MIN);
      end else begin
         pwm_count_in = pwm_step;
      end

      // Off at the brightness count takes priority over on at count zero.
      if (pwm_count_in == brightness_ff) begin
         light_level_in = 1'b0;
      end else if (pwm_count_in == 6'd0) begin
         light_level_in = 1'b1;
      end else begin
         light_level_in = light_level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_row_ff    <= 5'd0;
         scan_phase_ff  <= PH_PAGE;
         pwm_count_ff   <= 6'd0;
         pins_latch_ff  <= 8'd0;
         rs_level_ff    <= 1'b0;
         light_level_ff <= 1'b0;
         adc_toggle_ff  <= 1'b1;
         bus_level_ff   <= 8'd0;
         drive_level_ff <= 1'b1;
         strobe_ff      <= 1'b0;
      end else if (tick_go) begin
         page_row_ff    <= page_row_in;
         scan_phase_ff  <= scan_phase_in;
         pwm_count_ff   <= pwm_count_in;
         pins_latch_ff  <= pins_latch_in;
         rs_level_ff    <= rs_level_in;
         light_level_ff <= light_level_in;
         adc_toggle_ff  <= adc_toggle_in;
         bus_level_ff   <= bus_level_in;
         drive_level_ff <= drive_level_in;
         strobe_ff      <= strobe_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response slot
   // ---------------------------------------------------------------------
   assign rsp_valid_in = tick_go || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The ADC start level reported is the one before this tick's toggle.
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.data_out   = bus_level_ff;
   assign rsp_port.data_drive = drive_level_ff;
   assign rsp_port.reg_select = rs_level_ff;
   assign rsp_port.strobe_res = strobe_ff;
   assign rsp_port.backlight  = light_level_ff;
   assign rsp_port.adc_start  = ~adc_toggle_ff;
   assign rsp_port.keys       = ~pins_latch_ff;

endmodule

`default_nettype wire

/* hdl/lfrs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lfrs_checker
   import lfrs_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire [1:0] req_op,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_data_out,
   input wire       rsp_data_drive,
   input wire       rsp_strobe_res,
   input wire [7:0] rsp_keys
);

   // A pending response stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data_out) && $stable(rsp_keys))
      else $error("response payload changed while stalled");

   // The frame store sweep after reset keeps requests out.
   assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during the reset sweep");

   // A clear transaction starts a sweep, so the next cycle takes no request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_CLEAR |=> !req_ready)
      else $error("request taken right after a clear");

   // A released bus is only shown after the strobed set-column command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_drive |-> rsp_strobe_res && rsp_data_out == BUS_PULL)
      else $error("bus released without the pull-up byte and strobe");

endmodule

bind lcd_framebuffer_refresh_scanner_top lfrs_checker u_lfrs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .req_op         (req_port.op),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_data_out   (rsp_port.data_out),
   .rsp_data_drive (rsp_port.data_drive),
   .rsp_strobe_res (rsp_port.strobe_res),
   .rsp_keys       (rsp_port.keys)
);

`default_nettype wire

/* dv/lfrs_scan_checker.sv */
`timescale 1ns / 1ps

module lfrs_scan_checker
   import lfrs_pkg::*;
#(
   parameter int WIDTH      = 128,
   parameter int HEIGHT     = 64,
   parameter int BRIGHT_MAX = 32,
   parameter int BRIGHT_MIN = 0
) (
   input  wire   clock,
   input  wire   reset,
   lfrs_req_if   req_mon,
   lfrs_rsp_if   rsp_mon,
   lfrs_csr_if   csr_mon,
   output int    mismatch_count,
   output int    scans_due
);

   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [7:0] bus;
      logic       drive;
      logic       rs;
      logic       strobe;
      logic       light;
      logic       adc;
      logic [7:0] keys;
   } scan_out_type;

   // Shadow copy of the frame store and the scanner registers.
   logic [7:0] pix_mem [STORE_DEPTH];
   logic [4:0] row_q;
   logic [5:0] phase_q;
   logic [5:0] pwm_q;
   logic [7:0] latch_q;
   logic [7:0] bus_q;
   logic       rs_q;
   logic       light_q;
   logic       adc_q;
   logic       drive_q;
   logic [5:0] bright_q;

   scan_out_type scan_results_due[$];

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic plot_pixel(input logic [7:0] px, input logic [7:0] py, input logic ink);
      logic [7:0] mask;
      logic [4:0] col;
      logic [9:0] addr;
      if (px < WIDTH && py < HEIGHT) begin
         mask = 8'h80 >> px[2:0];
         col  = px[7:3];
         // The lower half of the screen lives in the right-hand columns.
         if (py >= 8'd32)
            col = col + 5'd16;
         addr = {col, py[4:0]};
         if (ink)
            pix_mem[addr] = pix_mem[addr] | mask;
         else
            pix_mem[addr] = pix_mem[addr] & ~mask;
      end
   endtask

   task automatic step_scan(input logic [7:0] pins, output scan_out_type res);
      logic strobe;
      logic adc;
      strobe = 1'b0;
      adc    = adc_q;
      adc_q  = ~adc_q;

      if (phase_q == PH_PAGE) begin
         rs_q  = 1'b0;
         row_q = row_q + 5'd1;
         bus_q = CMD_GFX | {3'b000, row_q};
      end else if (phase_q == PH_ADDR) begin
         bus_q = CMD_GFX;
      end else if (phase_q == PH_READ) begin
         latch_q = pins;
         drive_q = 1'b1;
      end else begin
         bus_q = pix_mem[{phase_q[4:0], row_q}];
      end

      if (phase_q != PH_READ) begin
         strobe = 1'b1;
         // Release the bus to the pull-ups ahead of the read phase.
         if (phase_q == PH_ADDR) begin
            bus_q   = BUS_PULL;
            drive_q = 1'b0;
         end
      end

      phase_q = phase_q + 6'd1;
      if (phase_q > PH_READ) begin
         phase_q = 6'd0;
         rs_q    = 1'b1;
      end

      pwm_q = pwm_q + 6'd1;
      if (pwm_q >= BRIGHT_MAX)
         pwm_q = 6'(BRIGHT_MIN);
      if (pwm_q == bright_q)
         light_q = 1'b0;
      else if (pwm_q == 6'd0)
         light_q = 1'b1;

      res.bus    = bus_q;
      res.drive  = drive_q;
      res.rs     = rs_q;
      res.strobe = strobe;
      res.light  = light_q;
      res.adc    = adc;
      res.keys   = ~latch_q;
   endtask

   task automatic check_scan(input scan_out_type want);
      if (rsp_mon.data_out !== want.bus)
         report_mismatch("data_out", int'(rsp_mon.data_out), int'(want.bus));
      if (rsp_mon.data_drive !== want.drive)
         report_mismatch("data_drive", int'(rsp_mon.data_drive), int'(want.drive));
      if (rsp_mon.reg_select !== want.rs)
         report_mismatch("reg_select", int'(rsp_mon.reg_select), int'(want.rs));
      if (rsp_mon.strobe_res !== want.strobe)
         report_mismatch("strobe_res", int'(rsp_mon.strobe_res), int'(want.strobe));
      if (rsp_mon.backlight !== want.light)
         report_mismatch("backlight", int'(rsp_mon.backlight), int'(want.light));
      if (rsp_mon.adc_start !== want.adc)
         report_mismatch("adc_start", int'(rsp_mon.adc_start), int'(want.adc));
      if (rsp_mon.keys !== want.keys)
         report_mismatch("keys", int'(rsp_mon.keys), int'(want.keys));
   endtask

   always @(posedge clock) begin
      scan_out_type res;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++)
            pix_mem[i] = 8'h00;
         row_q    = 5'd0;
         phase_q  = PH_PAGE;
         pwm_q    = 6'd0;
         latch_q  = 8'h00;
         bus_q    = 8'h00;
         rs_q     = 1'b0;
         light_q  = 1'b0;
         adc_q    = 1'b1;
         drive_q  = 1'b1;
         bright_q = 6'd0;
         mismatch_count = 0;
         scan_results_due.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            bright_q = csr_mon.brightness;

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (scan_results_due.size() == 0)
               report_mismatch("response with nothing outstanding", int'(rsp_mon.data_out), 0);
            else
               check_scan(scan_results_due.pop_front());
         end

         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.op)
               OP_DRAW: begin
                  plot_pixel(req_mon.x, req_mon.y, req_mon.color);
               end
               OP_CLEAR: begin
                  for (int i = 0; i < STORE_DEPTH; i++)
                     pix_mem[i] = 8'h00;
               end
               OP_TICK: begin
                  step_scan(req_mon.pins_in, res);
                  scan_results_due.push_back(res);
               end
               default: begin
               end
            endcase
         end
      end
      scans_due = scan_results_due.size();
   end

endmodule

/* dv/lcd_framebuffer_refresh_scanner_top_tb.sv */
`timescale 1ns / 1ps

module lcd_framebuffer_refresh_scanner_top_tb;
   import lfrs_pkg::*;

   // The op encoding leaves one code unused; the block must swallow it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // A clear sweeps the whole store at one byte per cycle and produces no
   // response, so before a brightness write we let that much time pass.
   localparam int SETTLE_CYCLES = 1100;

   // Longest honest quiet stretch: the reset sweep, a clear or the settle
   // wait, plus sender gaps and receiver stalls. The limit is several times that.
   localparam int IDLE_LIMIT = 6000;

   localparam int PHASE_ITEMS = 375;

   logic clock = 1'b0;
   logic reset;

   int mismatch_count;
   int scans_due;
   int quiet_cycles = 0;

   lfrs_req_if req_bus ();
   lfrs_rsp_if rsp_bus ();
   lfrs_csr_if csr_bus ();

   lcd_framebuffer_refresh_scanner_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // The checker mirrors the block from the accepted transactions and
   // compares every response; this module only drives and decides.
   lfrs_scan_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_count (mismatch_count),
      .scans_due      (scans_due)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Response back-pressure. A 16-bit pattern rotates one place per cycle
   // and its low bit is the ready. A new pattern is picked as its age runs
   // out: fully open, random, mostly open, or a single open slot with long
   // stalls. This moves the stalls across every phase of the block's work.
   logic [15:0] stall_pattern = 16'hFFFF;
   int          pattern_age   = 0;

   always @(posedge clock) begin
      if (pattern_age == 0) begin
         pattern_age <= 63;
         case ($urandom_range(0, 3))
            0: stall_pattern <= 16'hFFFF;
            1: stall_pattern <= 16'($urandom);
            2: stall_pattern <= 16'($urandom) | 16'($urandom);
            default: stall_pattern <= 16'h0001 << $urandom_range(0, 15);
         endcase
      end else begin
         pattern_age   <= pattern_age - 1;
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      end
      rsp_bus.ready <= stall_pattern[0];
   end

   // Watchdog: any accepted transaction on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request and hold it until it is taken. Valid is left high
   // so that a burst continues without a bubble; the caller lowers it.
   task automatic send_req(input logic [1:0] op, input logic [7:0] px, input logic [7:0] py,
                           input logic ink, input logic [7:0] pins);
      req_bus.valid   <= 1'b1;
      req_bus.op      <= op;
      req_bus.x       <= px;
      req_bus.y       <= py;
      req_bus.color   <= ink;
      req_bus.pins_in <= pins;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // Stop sending and wait until every tick response has been taken. The
   // count is looked at on the falling edge, after the checker has settled.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (scans_due != 0);
      @(posedge clock);
   endtask

   // Brightness is only changed with the block quiet: drained, then given
   // time for a clear that may still be sweeping the store.
   task automatic write_brightness(input logic [5:0] level);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.brightness <= level;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid <= 1'b0;
   endtask

   // Random traffic in bursts. Roughly half draws and half ticks, so the
   // scan keeps reading bytes that were recently drawn into; clears are
   // rare because each one costs a full sweep. Draws mostly land on screen,
   // with a share of full-range coordinates that also hit the off-screen
   // case. Unused ops are sent but not counted.
   task automatic run_traffic(input int n_items);
      int         sent;
      int         burst;
      int         gap;
      int         pick;
      logic [7:0] px;
      logic [7:0] py;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < n_items; i++) begin
            pick = $urandom_range(0, 199);
            if (pick < 2) begin
               send_req(OP_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
               sent++;
            end else if (pick < 6) begin
               send_req(OP_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
            end else if (pick < 96) begin
               if ($urandom_range(0, 9) == 0) begin
                  px = 8'($urandom);
                  py = 8'($urandom);
               end else begin
                  px = 8'($urandom_range(0, 127));
                  py = 8'($urandom_range(0, 63));
               end
               send_req(OP_DRAW, px, py, 1'($urandom), 8'($urandom));
               sent++;
            end else begin
               send_req(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
               sent++;
            end
         end
         // Now and then hold off until the response side is empty; otherwise
         // idle for a random gap, sometimes none at all.
         if ($urandom_range(0, 24) == 0) begin
            wait_drained();
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.op         <= OP_DRAW;
      req_bus.x          <= 8'h00;
      req_bus.y          <= 8'h00;
      req_bus.color      <= 1'b0;
      req_bus.pins_in    <= 8'h00;
      csr_bus.valid      <= 1'b0;
      csr_bus.brightness <= 6'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the light held dark. Pixels at the corners, on
      // row 1 (the first row the scan sends), in the folded lower half, off
      // screen in each direction, and one erased again. The first three
      // ticks then walk the set-page, set-column and read phases, the read
      // latching a pattern on the key lines, before data bytes follow.
      write_brightness(6'd0);
      send_req(OP_DRAW, 8'd0, 8'd0, 1'b1, 8'h00);
      send_req(OP_DRAW, 8'd127, 8'd63, 1'b1, 8'h00);
      send_req(OP_DRAW, 8'd127, 8'd1, 1'b1, 8'h00);
      send_req(OP_DRAW, 8'd0, 8'd1, 1'b1, 8'h00);
      send_req(OP_DRAW, 8'd9, 8'd1, 1'b1, 8'h00);
      send_req(OP_DRAW, 8'd64, 8'd33, 1'b1, 8'h00);
      send_req(OP_DRAW, 8'd128, 8'd1, 1'b1, 8'h00);
      send_req(OP_DRAW, 8'd3, 8'd64, 1'b1, 8'h00);
      send_req(OP_DRAW, 8'd255, 8'd255, 1'b1, 8'hFF);
      send_req(OP_DRAW, 8'd0, 8'd1, 1'b0, 8'h00);
      send_req(OP_UNUSED, 8'd255, 8'd255, 1'b1, 8'hFF);
      send_req(OP_TICK, 8'd0, 8'd0, 1'b0, 8'h00);
      send_req(OP_TICK, 8'd255, 8'd255, 1'b1, 8'hFF);
      send_req(OP_TICK, 8'd0, 8'd0, 1'b0, 8'hA5);
      for (int i = 0; i < 8; i++)
         send_req(OP_TICK, 8'd0, 8'd0, 1'b0, 8'h5A);
      send_req(OP_CLEAR, 8'd0, 8'd0, 1'b0, 8'h00);
      send_req(OP_TICK, 8'd0, 8'd0, 1'b0, 8'h00);
      send_req(OP_TICK, 8'd0, 8'd0, 1'b0, 8'hFF);

      // Random phases, each under its own brightness: a level the counter
      // never reaches (light stays on), a one-count pulse, the longest
      // reachable level, and a random one.
      write_brightness(6'd32);
      run_traffic(PHASE_ITEMS);
      write_brightness(6'd1);
      run_traffic(PHASE_ITEMS);
      write_brightness(6'd31);
      run_traffic(PHASE_ITEMS);
      write_brightness(6'($urandom_range(2, 30)));
      run_traffic(PHASE_ITEMS);

      // Let the last responses come back and any trailing clear finish, so
      // that a stray extra response would still be caught.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
